/* hw/rtl/mexp_pkg.sv */
// Shared constants, types and request/response structs of the modular exponentiation block.
package mexp_pkg;

  localparam int MOD_WIDTH   = 31;
  localparam int EXP_WIDTH   = 32;
  localparam int BASE_WIDTH  = 31;
  localparam int RES_WIDTH   = 31;
  localparam int OP_WIDTH    = (BASE_WIDTH > MOD_WIDTH) ? BASE_WIDTH : MOD_WIDTH;
  localparam int CNT_WIDTH   = $clog2(OP_WIDTH);
  localparam int IN_BITS     = 1 + BASE_WIDTH + EXP_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RES_WIDTH + 7) / 8) * 8;

  typedef logic [MOD_WIDTH-1:0]  mod_t;
  typedef logic [EXP_WIDTH-1:0]  exp_t;
  typedef logic [OP_WIDTH-1:0]   opnd_t;
  typedef logic [RES_WIDTH-1:0]  res_t;
  typedef logic [CNT_WIDTH-1:0]  cnt_t;

  localparam mod_t MODULUS_RESET = mod_t'(1000000007);

  // Opcode values of the input request
  localparam logic OPC_POWER   = 1'b0;
  localparam logic OPC_INVERSE = 1'b1;

  // Request to the shared modular multiplier
  typedef struct packed {
    logic  start;
    opnd_t a;
    mod_t  b;
  } mm_req_t;

  // Response of the shared modular multiplier
  typedef struct packed {
    logic done;
    mod_t product;
  } mm_rsp_t;

endpackage

/* hw/rtl/modular_exponentiation.sv */
// Top level: square-and-multiply sequencer around a shared modular multiplier.
//
//  Port group       Dir  Carries
//  s_axis_*         in   request: opcode, base_value, exponent
//  m_axis_*         out  result: residue
//  cfg_we/wdata     in   modulus register write
//
// Each modular product is computed by the bit-serial multiplier.
// An item reduces the base once, then does one square per exponent bit below the top
// set bit and one multiply per set bit; a zero modulus skips straight to a zero result.
// Reset loads the modulus with 1000000007 and empties the output register.
// The input is ready only when the sequencer is idle; a waiting result does
// not block the next request, but its completion waits for the output slot.
module modular_exponentiation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // opcode [0], base_value [31:1], exponent [63:32]
  input  logic [mexp_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // residue [30:0], zero above
  output logic [mexp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]    cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_FINISH
  } state_e;

  state_e             state_q;
  mexp_pkg::mod_t     modulus_q;
  mexp_pkg::mod_t     acc_q;
  mexp_pkg::mod_t     base_q;
  mexp_pkg::exp_t     exp_q;
  mexp_pkg::mm_req_t  req_q;
  mexp_pkg::mm_rsp_t  rsp;
  logic               out_valid_q;
  mexp_pkg::res_t     out_data_q;

  logic               in_accept;
  logic               in_opcode;
  mexp_pkg::opnd_t    in_base;
  mexp_pkg::exp_t     in_exp;
  mexp_pkg::exp_t     exp_sel;
  mexp_pkg::exp_t     exp_cur;
  logic               out_free;

  // Unpack the request, pick the exponent, and derive the current exponent and a free output slot
  always_comb begin
    in_accept = s_axis_tvalid_i && s_axis_tready_o;
    in_opcode = s_axis_tdata_i[0];
    in_base   = mexp_pkg::opnd_t'(s_axis_tdata_i[mexp_pkg::BASE_WIDTH:1]);
    in_exp    = s_axis_tdata_i[mexp_pkg::BASE_WIDTH+mexp_pkg::EXP_WIDTH:
                               mexp_pkg::BASE_WIDTH+1];
    if (in_opcode == mexp_pkg::OPC_INVERSE) begin
      exp_sel = (modulus_q >= mexp_pkg::mod_t'(2)) ?
                mexp_pkg::exp_t'(modulus_q - mexp_pkg::mod_t'(2)) : '0;
    end else begin
      exp_sel = in_exp;
    end
    exp_cur  = (state_q == S_SQR) ? (exp_q >> 1) : exp_q;
    out_free = !out_valid_q || m_axis_tready_i;
  end

  // Sequencer, operand registers, modulus and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      modulus_q   <= mexp_pkg::MODULUS_RESET;
      acc_q       <= '0;
      base_q      <= '0;
      exp_q       <= '0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
      // Load a finished result into a free slot, drop an accepted one
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= mexp_pkg::res_t'(acc_q);
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            exp_q <= exp_sel;
            if (modulus_q == '0) begin
              acc_q   <= '0;
              state_q <= S_FINISH;
            end else begin
              acc_q   <= mexp_pkg::mod_t'(1);
              req_q   <= '{start: 1'b1, a: in_base, b: mexp_pkg::mod_t'(1)};
              state_q <= S_REDUCE;
            end
          end
        end
        S_REDUCE, S_SQR: begin
          if (rsp.done) begin
            base_q <= rsp.product;
            exp_q  <= exp_cur;
            if (exp_cur == '0) begin
              state_q <= S_FINISH;
            end else if (exp_cur[0]) begin
              req_q   <= '{start: 1'b1, a: mexp_pkg::opnd_t'(acc_q), b: rsp.product};
              state_q <= S_MUL;
            end else begin
              req_q   <= '{start: 1'b1, a: mexp_pkg::opnd_t'(rsp.product),
                           b: rsp.product};
              state_q <= S_SQR;
            end
          end else begin
            // Hold the start pulse to one cycle
            req_q.start <= 1'b0;
          end
        end
        S_MUL: begin
          if (rsp.done) begin
            acc_q <= rsp.product;
            // Skip the square after the top exponent bit
            if ((exp_q >> 1) == '0) begin
              state_q <= S_FINISH;
            end else begin
              req_q   <= '{start: 1'b1, a: mexp_pkg::opnd_t'(base_q), b: base_q};
              state_q <= S_SQR;
            end
          end else begin
            req_q.start <= 1'b0;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          req_q.start <= 1'b0;
          state_q     <= S_IDLE;
        end
      endcase
    end
  end

  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_q),
    .modulus_i (modulus_q),
    .rsp_o     (rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mexp_pkg::OUT_TDATA_W'(out_data_q);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_done_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_REDUCE || state_q == S_MUL || state_q == S_SQR))
    else $error("product returned outside a working state");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not loaded into free output slot");
`endif

endmodule

/* hw/rtl/mexp_mulmod.sv */
// Bit-serial interleaved modular multiplier: one operand bit per cycle.
module mexp_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mexp_pkg::mm_req_t req_i,
  input  mexp_pkg::mod_t    modulus_i,
  output mexp_pkg::mm_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  mexp_pkg::cnt_t   cnt_q, cnt_d;
  mexp_pkg::opnd_t  a_q, a_d;
  mexp_pkg::mod_t   b_q, b_d;
  mexp_pkg::mod_t   r_q, r_d;

  logic [mexp_pkg::MOD_WIDTH+1:0] sum, m_ext, t1, t2;

  // Double, add the addend on a set bit, then fold back below the modulus
  always_comb begin
    m_ext = {2'b00, modulus_i};
    sum   = {1'b0, r_q, 1'b0} +
            (a_q[mexp_pkg::OP_WIDTH-1] ? {2'b00, b_q} : '0);
    t1    = (sum >= m_ext) ? (sum - m_ext) : sum;
    t2    = (t1 >= m_ext) ? (t1 - m_ext) : t1;
  end

  // Sequence the steps of one product
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = mexp_pkg::cnt_t'(mexp_pkg::OP_WIDTH - 1);
      a_d    = req_i.a;
      b_d    = req_i.b;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = t2[mexp_pkg::MOD_WIDTH-1:0];
      a_d = a_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      r_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      a_q    <= a_d;
      b_q    <= b_d;
      r_q    <= r_d;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = r_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier restarted while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == '0) |=> (done_q && !busy_q))
    else $error("last step did not raise done");
`endif

endmodule
